/* src/ksm_pkg.sv */
package ksm_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned SEL_W     = 3;

    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam logic REG_ACTIVE  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_APPLY,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic do_update;
        logic scan_step;
        logic apply;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic active;
        logic out_ready;
        logic scan_done;
    } stat_t;

endpackage

/* src/ksm_alu.sv */
module ksm_alu (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        sub,
    output logic [31:0] sum
);
    import ksm_pkg::*;

    // one adder: a + b, or a - b in two's complement
    assign sum = a + (b ^ {TIME_W{sub}}) + TIME_W'(sub);

endmodule

/* src/ksm_ctrl.sv */
module ksm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  ksm_pkg::stat_t stat,
    output ksm_pkg::ctrl_t ctrl
);
    import ksm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.in_valid) begin
                    if (stat.in_op == OP_UPDATE) begin
                        state_next = ST_UPDATE;
                    end else if (stat.active) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_UPDATE: state_next = ST_RESULT;
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: state_next = ST_RESULT;
            ST_RESULT: begin
                if (stat.out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:   ctrl.in_ready  = 1'b1;
            ST_UPDATE: ctrl.do_update = 1'b1;
            ST_SCAN:   ctrl.scan_step = 1'b1;
            ST_APPLY:  ctrl.apply     = 1'b1;
            ST_RESULT: ctrl.out_valid = 1'b1;
            default:   ctrl = '0;
        endcase
    end

endmodule

/* src/kill_switch_monitor_unit.sv */
// kill switch monitor: folds up to NUM_SWITCHES kill switches into one kill state.
// an update request (tuser 0) records a switch's assert and need-refresh flags, enables it,
// and sets its deadline to now_ms + timeout_ms; with monitor_active set, an asserting
// switch issues a kill with a stop pulse. with monitor_active set, a refresh (tuser 1)
// walks the switch table one entry per cycle through a single shared adder/comparator,
// killing on any asserting or expired enabled switch or when none is enabled, else
// releasing; an inactive refresh leaves the kill state alone. one request is in flight at
// a time: an update goes through the update state, an active refresh the table walk (it
// stops at the first killing entry) and apply. each request returns exactly one result.
module kill_switch_monitor_unit #(
    parameter int NUM_SWITCHES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // switch_index[2:0], assert_kill[3], needs_refresh[4],
                                  // now_ms[36:5], zero[39:37]
    input  logic        s_tuser,  // op: 0 update, 1 refresh
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // kill_asserted[0], stop_pulse[1], last_change_ms[33:2],
                                  // zero[39:34]
);
    import ksm_pkg::*;

    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
    localparam int CNT_W = $clog2(NUM_SWITCHES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SWITCHES - 1);

    ctrl_t ctrl;
    stat_t stat;

    logic                 active_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic [SEL_W-1:0]   idx_reg;
    logic               asrt_in_reg;
    logic               need_in_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [NUM_SWITCHES-1:0] en_reg;
    logic [NUM_SWITCHES-1:0] asrt_reg;
    logic [NUM_SWITCHES-1:0] need_reg;
    logic [TIME_W-1:0]       deadline_reg [NUM_SWITCHES];

    logic              kill_state_reg;
    logic [TIME_W-1:0] change_reg;
    logic              pulse_reg;
    logic              hit_reg;
    logic              any_en_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;

    logic              cfg_wr;
    logic              s_fire;
    logic              idx_ok;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rd_idx;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic [TIME_W-1:0] alu_sum;
    logic              hit_now;
    logic              scan_last;
    logic              kill_next;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ACTIVE:  active_reg  <= pwdata[0];
                REG_TIMEOUT: timeout_reg <= pwdata[TIMEOUT_W-1:0];
                default:     active_reg  <= active_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ACTIVE:  prdata = {31'b0, active_reg};
            REG_TIMEOUT: prdata = {16'b0, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    // sequencer
    assign stat.in_valid  = s_tvalid;
    assign stat.in_op     = s_tuser;
    assign stat.active    = active_reg;
    assign stat.out_ready = m_tready;
    assign stat.scan_done = hit_now | scan_last;

    ksm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    assign s_tready = ctrl.in_ready;
    assign m_tvalid = ctrl.out_valid;
    assign s_fire   = s_tvalid & ctrl.in_ready;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            idx_reg     <= s_tdata[2:0];
            asrt_in_reg <= s_tdata[3];
            need_in_reg <= s_tdata[4];
            now_reg     <= s_tdata[36:5];
        end
    end

    // shared adder: now + timeout on update, deadline - now on scan
    assign wr_idx = IDX_W'(idx_reg);
    assign rd_idx = scan_cnt_reg[IDX_W-1:0];
    assign idx_ok = 32'(idx_reg) < 32'(NUM_SWITCHES);
    assign alu_a  = ctrl.scan_step ? deadline_reg[rd_idx] : now_reg;
    assign alu_b  = ctrl.scan_step ? now_reg : {16'b0, timeout_reg};

    ksm_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (ctrl.scan_step),
        .sum (alu_sum)
    );

    assign hit_now   = ctrl.scan_step & en_reg[rd_idx]
                     & (asrt_reg[rd_idx] | (need_reg[rd_idx] & alu_sum[TIME_W-1]));
    assign scan_last = scan_cnt_reg == LAST_CNT;
    assign kill_next = hit_reg | ~any_en_reg;

    // switch table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= '0;
            asrt_reg <= '0;
            need_reg <= '0;
        end else if (ctrl.do_update && idx_ok) begin
            en_reg[wr_idx]   <= 1'b1;
            asrt_reg[wr_idx] <= asrt_in_reg;
            need_reg[wr_idx] <= need_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.do_update && idx_ok) begin
            deadline_reg[wr_idx] <= alu_sum;
        end
    end

    // scan walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            hit_reg      <= 1'b0;
            any_en_reg   <= 1'b0;
        end else if (s_fire) begin
            scan_cnt_reg <= '0;
            hit_reg      <= 1'b0;
            any_en_reg   <= 1'b0;
        end else if (ctrl.scan_step) begin
            scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            hit_reg      <= hit_reg | hit_now;
            any_en_reg   <= any_en_reg | en_reg[rd_idx];
        end
    end

    // kill state and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kill_state_reg <= 1'b1;
            change_reg     <= '0;
            pulse_reg      <= 1'b0;
        end else if (s_fire) begin
            pulse_reg <= 1'b0;
        end else if (ctrl.do_update) begin
            if (idx_ok && active_reg && asrt_in_reg) begin
                kill_state_reg <= 1'b1;
                change_reg     <= now_reg;
                pulse_reg      <= 1'b1;
            end
        end else if (ctrl.apply) begin
            if (kill_next != kill_state_reg) begin
                kill_state_reg <= kill_next;
                change_reg     <= now_reg;
                pulse_reg      <= kill_next;
            end
        end
    end

    assign m_tdata = {6'b0, change_reg, pulse_reg, kill_state_reg};

    a_pulse_means_kill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && pulse_reg |-> kill_state_reg)
        else $error("stop pulse without kill");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request accepted while result pending");

    a_apply_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.apply |=> kill_state_reg == $past(hit_reg || !any_en_reg))
        else $error("kill state disagrees with scan");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.scan_step |-> scan_cnt_reg <= LAST_CNT)
        else $error("scan past last switch");

endmodule
